// ===== rtl/core/stt_pkg.sv =====
package stt_pkg;

    localparam int NUM_TIMERS_DEF = 32;
    localparam int HDL_W          = 6;
    localparam int MAX_EXPIRY     = 31;
    localparam logic [31:0] DL_MAX = 32'hffffffff;

    typedef enum logic [2:0] {
        CMD_ALLOC   = 3'd0,
        CMD_FREE    = 3'd1,
        CMD_INIT    = 3'd2,
        CMD_SETTIME = 3'd3,
        CMD_TICK    = 3'd4
    } cmd_t;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_EXPIRY = 2'd1;
    localparam logic [1:0] KIND_SWITCH = 2'd2;

    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_NOFREE = 2'd1;
    localparam logic [1:0] STS_BAD    = 2'd2;

    localparam logic [1:0] ES_FREE  = 2'd0;
    localparam logic [1:0] ES_ALLOC = 2'd1;
    localparam logic [1:0] ES_RUN   = 2'd2;

    localparam logic [7:0] CFG_TT_ENABLE = 8'd0;
    localparam logic [7:0] CFG_TT_HANDLE = 8'd1;

    typedef struct packed {
        logic             valid;
        logic [31:0]      dl;
        logic [HDL_W-1:0] hdl;
    } cell_t;

    typedef struct packed {
        logic             ins;
        logic             pop;
        logic [31:0]      dl;
        logic [HDL_W-1:0] hdl;
    } chain_ctl_t;

endpackage

// ===== rtl/core/stt_ram.sv =====
module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/stt_cell.sv =====
module stt_cell
    import stt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  chain_ctl_t ctl,
    input  cell_t      left,
    input  logic       left_take,
    input  cell_t      right,
    output cell_t      cur,
    output logic       take
);

    cell_t cell_reg;
    cell_t cell_next;

    // new timer goes ahead of any entry with an equal or later deadline
    assign take = !cell_reg.valid || (ctl.dl <= cell_reg.dl);
    assign cur  = cell_reg;

    always_comb
    begin
        cell_next = cell_reg;
        if (ctl.ins)
        begin
            if (left_take)
            begin
                cell_next = left;
            end
            else if (take)
            begin
                cell_next.valid = 1'b1;
                cell_next.dl    = ctl.dl;
                cell_next.hdl   = ctl.hdl;
            end
        end
        else if (ctl.pop)
        begin
            cell_next = right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

endmodule

// ===== rtl/core/sorted_software_timer_manager.sv =====
// Sorted timer pool. Requests enter on s_* (command in s_tuser), one at a time;
// every request returns one status result on m_*, except tick, which returns
// zero or more expiry results and at most one task-switch result, m_tlast on
// the final one. Configuration writes on cfg_* are taken at any time and
// should be issued while the block is idle.
// Running timers sit in a chain of NUM_TIMERS-1 cells ordered by deadline;
// the head cell is the earliest timer, an empty head stands for the sentinel.
// Alloc scans the entry states from handle 1, one entry scanned per cycle; tick
// pops each due head timer and reads its payload from RAM for an expiry result,
// while a popped task timer gives no expiry result but one task-switch result
// at the end. Settime inserts into the chain, all cells comparing in parallel.
// One request is in flight at a time; s_tready is high only when the block
// is idle.
// Reset: all timers but handle 0 free (handle 0 marked running), chain empty,
// tick count zero; no clearing pass. A stalled m_tready holds the result register and the block waits.
module sorted_software_timer_manager
    import stt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // handle[5:0], dest_queue[13:6], payload[45:14],
                                  // delay_ticks[77:46], zero pad
    input  logic [2:0]  s_tuser,  // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // status[1:0], result_handle[7:2], out_queue[15:8],
                                  // out_data[47:16]
    output logic [1:0]  m_tuser,  // kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [5:0]  cfg_data
);

    localparam int HW = $clog2(NUM_TIMERS);
    localparam int NC = NUM_TIMERS - 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_SCAN = 7'b0000100,
        S_INS  = 7'b0001000,
        S_TCHK = 7'b0010000,
        S_TRD  = 7'b0100000,
        S_OUTW = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [5:0]  hdl_reg, hdl_next;
    logic [7:0]  q_reg, q_next;
    logic [31:0] d_reg, d_next;
    logic [31:0] dt_reg, dt_next;
    logic [31:0] dl_reg, dl_next;
    logic [31:0] tick_reg, tick_next;
    logic [HW-1:0] scan_reg, scan_next;
    logic [4:0]  k_reg, k_next;
    logic        ts_reg, ts_next;
    logic [5:0]  exp_reg, exp_next;
    logic        ret_reg, ret_next;
    logic        ov_reg, ov_next;
    logic [1:0]  okind_reg, okind_next;
    logic [1:0]  osts_reg, osts_next;
    logic [5:0]  ohdl_reg, ohdl_next;
    logic [7:0]  oq_reg, oq_next;
    logic [31:0] od_reg, od_next;
    logic        olast_reg, olast_next;
    logic        tte_reg;
    logic [5:0]  tth_reg;

    logic [1:0] est_reg [NUM_TIMERS];
    logic          est_we;
    logic [HW-1:0] est_wa;
    logic [1:0]    est_wd;
    logic [HW-1:0] rd_idx;
    logic [1:0]    est_rd;

    logic          ram_we;
    logic [39:0]   ram_rdata;

    chain_ctl_t ctl;
    cell_t      cells [NC];
    logic       takes [NC];
    cell_t      head;
    logic       hdl_ok;
    logic       due;
    logic       due_after;
    logic [HW-1:0] hidx;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = ov_reg;
    assign m_tuser   = okind_reg;
    assign m_tlast   = olast_reg;
    assign m_tdata   = {od_reg, oq_reg, ohdl_reg, osts_reg};

    assign hidx   = hdl_reg[HW-1:0];
    assign hdl_ok = (hdl_reg != 6'd0) && ({1'b0, hdl_reg} < 7'(NUM_TIMERS));
    assign rd_idx = (state_reg == S_SCAN) ? scan_reg : hidx;
    assign est_rd = est_reg[rd_idx];
    assign head   = cells[0];
    assign due       = head.valid && (head.dl <= tick_reg) && (k_reg < 5'(MAX_EXPIRY));
    assign due_after = head.valid && (head.dl <= tick_reg)
                       && ((k_reg + 5'd1) < 5'(MAX_EXPIRY));

    assign ctl.ins = (state_reg == S_INS);
    assign ctl.pop = (state_reg == S_TCHK) && due;
    assign ctl.dl  = dl_reg;
    assign ctl.hdl = hdl_reg;

    genvar gi;
    generate
        for (gi = 0; gi < NC; gi++)
        begin : g_cell
            cell_t c_left;
            cell_t c_right;
            logic  c_ltake;
            if (gi == 0)
            begin : g_first
                assign c_left  = '0;
                assign c_ltake = 1'b0;
            end
            else
            begin : g_mid
                assign c_left  = cells[gi-1];
                assign c_ltake = takes[gi-1];
            end
            if (gi == NC - 1)
            begin : g_last
                assign c_right = '0;
            end
            else
            begin : g_inner
                assign c_right = cells[gi+1];
            end
            stt_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .left      (c_left),
                .left_take (c_ltake),
                .right     (c_right),
                .cur       (cells[gi]),
                .take      (takes[gi])
            );
        end
    endgenerate

    stt_ram #(
        .WIDTH (40),
        .DEPTH (NUM_TIMERS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (hidx),
        .wdata ({q_reg, d_reg}),
        .raddr (head.hdl[HW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        hdl_next   = hdl_reg;
        q_next     = q_reg;
        d_next     = d_reg;
        dt_next    = dt_reg;
        dl_next    = dl_reg;
        tick_next  = tick_reg;
        scan_next  = scan_reg;
        k_next     = k_reg;
        ts_next    = ts_reg;
        exp_next   = exp_reg;
        ret_next   = ret_reg;
        ov_next    = ov_reg;
        okind_next = okind_reg;
        osts_next  = osts_reg;
        ohdl_next  = ohdl_reg;
        oq_next    = oq_reg;
        od_next    = od_reg;
        olast_next = olast_reg;
        est_we     = 1'b0;
        est_wa     = hidx;
        est_wd     = ES_FREE;
        ram_we     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next  = s_tuser;
                    hdl_next  = s_tdata[5:0];
                    q_next    = s_tdata[13:6];
                    d_next    = s_tdata[45:14];
                    dt_next   = s_tdata[77:46];
                    scan_next = HW'(1);
                    k_next    = 5'd0;
                    ts_next   = 1'b0;
                    if (s_tuser == CMD_TICK)
                    begin
                        tick_next  = tick_reg + 32'd1;
                        state_next = S_TCHK;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                ov_next    = 1'b1;
                okind_next = KIND_STATUS;
                osts_next  = STS_OK;
                ohdl_next  = 6'd0;
                oq_next    = 8'd0;
                od_next    = 32'd0;
                olast_next = 1'b1;
                ret_next   = 1'b0;
                state_next = S_OUTW;
                unique case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        ov_next    = 1'b0;
                        state_next = S_SCAN;
                    end
                    CMD_FREE:
                    begin
                        if (!hdl_ok || est_rd == ES_RUN)
                        begin
                            osts_next = STS_BAD;
                        end
                        else
                        begin
                            est_we = 1'b1;
                            est_wd = ES_FREE;
                        end
                    end
                    CMD_INIT:
                    begin
                        if (!hdl_ok)
                        begin
                            osts_next = STS_BAD;
                        end
                        else
                        begin
                            ram_we = 1'b1;
                        end
                    end
                    CMD_SETTIME:
                    begin
                        if (!hdl_ok || est_rd != ES_ALLOC)
                        begin
                            osts_next = STS_BAD;
                        end
                        else
                        begin
                            est_we     = 1'b1;
                            est_wd     = ES_RUN;
                            dl_next    = tick_reg + dt_reg;
                            ov_next    = 1'b0;
                            state_next = S_INS;
                        end
                    end
                    default:
                    begin
                        osts_next = STS_BAD;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (est_rd == ES_FREE)
                begin
                    est_we     = 1'b1;
                    est_wa     = scan_reg;
                    est_wd     = ES_ALLOC;
                    ov_next    = 1'b1;
                    ohdl_next  = 6'(scan_reg);
                    state_next = S_OUTW;
                end
                else if (scan_reg == HW'(NUM_TIMERS - 1))
                begin
                    ov_next    = 1'b1;
                    osts_next  = STS_NOFREE;
                    state_next = S_OUTW;
                end
                else
                begin
                    scan_next = scan_reg + HW'(1);
                end
            end
            S_INS:
            begin
                ov_next    = 1'b1;
                state_next = S_OUTW;
            end
            S_TCHK:
            begin
                if (due)
                begin
                    est_we     = 1'b1;
                    est_wa     = head.hdl[HW-1:0];
                    est_wd     = ES_ALLOC;
                    exp_next   = head.hdl;
                    state_next = S_TRD;
                end
                else if (ts_reg)
                begin
                    ts_next    = 1'b0;
                    ov_next    = 1'b1;
                    okind_next = KIND_SWITCH;
                    osts_next  = STS_OK;
                    ohdl_next  = tth_reg;
                    oq_next    = 8'd0;
                    od_next    = 32'd0;
                    olast_next = 1'b1;
                    ret_next   = 1'b0;
                    state_next = S_OUTW;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_TRD:
            begin
                if (tte_reg && exp_reg == tth_reg)
                begin
                    ts_next    = 1'b1;
                    state_next = S_TCHK;
                end
                else
                begin
                    ov_next    = 1'b1;
                    okind_next = KIND_EXPIRY;
                    osts_next  = STS_OK;
                    ohdl_next  = exp_reg;
                    oq_next    = ram_rdata[39:32];
                    od_next    = ram_rdata[31:0];
                    olast_next = !due_after && !ts_reg;
                    k_next     = k_reg + 5'd1;
                    ret_next   = 1'b1;
                    state_next = S_OUTW;
                end
            end
            S_OUTW:
            begin
                if (m_tready)
                begin
                    ov_next    = 1'b0;
                    state_next = ret_reg ? S_TCHK : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tick_reg  <= 32'd0;
            ov_reg    <= 1'b0;
            ret_reg   <= 1'b0;
            ts_reg    <= 1'b0;
            k_reg     <= 5'd0;
            tte_reg   <= 1'b0;
            tth_reg   <= 6'd0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                est_reg[i] <= (i == 0) ? ES_RUN : ES_FREE;
            end
        end
        else
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            ov_reg    <= ov_next;
            ret_reg   <= ret_next;
            ts_reg    <= ts_next;
            k_reg     <= k_next;
            if (est_we)
            begin
                est_reg[est_wa] <= est_wd;
            end
            if (cfg_valid)
            begin
                if (cfg_index == CFG_TT_ENABLE)
                begin
                    tte_reg <= cfg_data[0];
                end
                else if (cfg_index == CFG_TT_HANDLE)
                begin
                    tth_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        hdl_reg   <= hdl_next;
        q_reg     <= q_next;
        d_reg     <= d_next;
        dt_reg    <= dt_next;
        dl_reg    <= dl_next;
        scan_reg  <= scan_next;
        exp_reg   <= exp_next;
        okind_reg <= okind_next;
        osts_reg  <= osts_next;
        ohdl_reg  <= ohdl_next;
        oq_reg    <= oq_next;
        od_reg    <= od_next;
        olast_reg <= olast_next;
    end

endmodule
